// ===== rtl/assert_macros.svh =====
// assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, quiet while reset is held
`define OWFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every rising clock edge, also during reset
`define OWFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/owfd_pkg.sv =====
// types and constants of the pulse-width weather frame decoder
`timescale 1ns / 1ps

package owfd_pkg;

  localparam int unsigned TimeW    = 16;
  localparam int unsigned CountW   = 7;
  localparam int unsigned WordW    = 64;
  localparam int unsigned SerialW  = 8;
  localparam int unsigned GapW     = TimeW + 2;

  // reset values of the configuration registers
  localparam logic [TimeW-1:0]  ShortReset = 16'd200;
  localparam logic [TimeW-1:0]  LongReset  = 16'd400;
  localparam logic [TimeW-1:0]  TolReset   = 16'd90;
  localparam logic [CountW-1:0] BitsReset  = 7'd64;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SHORT_TIME = 2'd0,
    CFG_LONG_TIME  = 2'd1,
    CFG_TOLERANCE  = 2'd2,
    CFG_FRAME_BITS = 2'd3
  } cfg_idx_e;

  // classification of one pulse pair
  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_FAIL = 2'd2
  } pair_kind_e;

  // classified request passed from front to back
  typedef struct packed {
    pair_kind_e kind;
    logic       eoc;
  } owfd_item_t;

endpackage

// ===== rtl/ook_pwm_weather_frame_decoder.sv =====
// Path: a pair is classified combinationally and queued; any result is registered.
// Throughput: one pulse pair per cycle unless the output stalls, set by the back end's
// combinational shift and checksum; a QUEUE_DEPTH-entry request queue absorbs them.
// Reset: asynchronous, active low; clears frame state, queue and result valid, and
// returns the configuration registers to their nominal values.
`timescale 1ns / 1ps

module ook_pwm_weather_frame_decoder import owfd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [TimeW-1:0]  cfg_wdata_i,
  // pulse pair stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,  // high_time [15:0], low_time [31:16]
  input  logic              s_axis_tlast,  // end_of_capture
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [79:0]       m_axis_tdata,  // frame_data [63:0], bit_count [70:64],
                                           // serial_id [78:71], zero [79]
  output logic              m_axis_tuser   // status
);

  owfd_item_t         fr_item, q_item;
  logic [CountW-1:0]  frame_bits;
  logic               q_full, q_valid, q_pop;
  logic               res_status;
  logic [WordW-1:0]   res_word;
  logic [CountW-1:0]  res_count;
  logic [SerialW-1:0] res_serial;

  // classification
  owfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .high_time_i  (s_axis_tdata[15:0]),
    .low_time_i   (s_axis_tdata[31:16]),
    .eoc_i        (s_axis_tlast),
    .item_o       (fr_item),
    .frame_bits_o (frame_bits)
  );

  assign s_axis_tready = !q_full;

  // decoupling queue
  owfd_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .item_i  (fr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // frame assembly and decision
  owfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_bits_i (frame_bits),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (res_status),
    .out_word_o   (res_word),
    .out_count_o  (res_count),
    .out_serial_o (res_serial)
  );

  assign m_axis_tdata = {1'b0, res_serial, res_count, res_word};
  assign m_axis_tuser = res_status;

endmodule

// ===== rtl/owfd_front.sv =====
// front end: configuration registers and pulse pair classification
`timescale 1ns / 1ps

module owfd_front import owfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [TimeW-1:0]  cfg_wdata_i,
  input  logic [TimeW-1:0]  high_time_i,
  input  logic [TimeW-1:0]  low_time_i,
  input  logic              eoc_i,
  output owfd_item_t        item_o,
  output logic [CountW-1:0] frame_bits_o
);

  logic [TimeW-1:0]  short_q, long_q, tol_q;
  logic [CountW-1:0] bits_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= ShortReset;
      long_q  <= LongReset;
      tol_q   <= TolReset;
      bits_q  <= BitsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SHORT_TIME: short_q <= cfg_wdata_i;
        CFG_LONG_TIME:  long_q  <= cfg_wdata_i;
        CFG_TOLERANCE:  tol_q   <= cfg_wdata_i;
        CFG_FRAME_BITS: bits_q  <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign frame_bits_o = bits_q;

  // absolute difference strictly below the tolerance
  function automatic logic near_time(logic [TimeW-1:0] t, logic [TimeW-1:0] nom,
                                     logic [TimeW-1:0] tol);
    logic [TimeW-1:0] d;
    d = (t > nom) ? (t - nom) : (nom - t);
    return d < tol;
  endfunction

  logic            hl, hs, ll, ls, gap_hit;
  logic [GapW-1:0] gap;

  // pair classification, rules tried in priority order
  always_comb begin
    hl      = near_time(high_time_i, long_q, tol_q);
    hs      = near_time(high_time_i, short_q, tol_q);
    ll      = near_time(low_time_i, long_q, tol_q);
    ls      = near_time(low_time_i, short_q, tol_q);
    gap     = GapW'(long_q) + {long_q, 1'b0};
    gap_hit = GapW'(low_time_i) > gap;
    item_o.eoc = eoc_i;
    if (hl && ls) begin
      item_o.kind = KIND_ONE;
    end else if (hs && ll) begin
      item_o.kind = KIND_ZERO;
    end else if (hs && gap_hit) begin
      item_o.kind = KIND_ZERO;
    end else if (hl && gap_hit) begin
      item_o.kind = KIND_ONE;
    end else begin
      item_o.kind = KIND_FAIL;
    end
  end

endmodule

// ===== rtl/owfd_queue.sv =====
// short request queue between front and back
`timescale 1ns / 1ps

module owfd_queue import owfd_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  owfd_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output owfd_item_t item_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  owfd_item_t       slots_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`include "assert_macros.svh"
  `OWFD_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "queue count above depth")
  `OWFD_ASSERT(a_cnt_step, (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1),
               "queue count missed a push")

endmodule

// ===== rtl/owfd_back.sv =====
// back end: bit shifting, frame decision, checksum and result register
`timescale 1ns / 1ps

module owfd_back import owfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CountW-1:0]  frame_bits_i,
  input  logic               q_valid_i,
  input  owfd_item_t         q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_status_o,
  output logic [WordW-1:0]   out_word_o,
  output logic [CountW-1:0]  out_count_o,
  output logic [SerialW-1:0] out_serial_o
);

  logic [WordW-1:0]   word_q, word_d;
  logic [CountW-1:0]  bits_q, bits_d;
  logic               decided_q, decided_d;
  logic               out_valid_q;
  logic               status_q;
  logic [WordW-1:0]   res_word_q;
  logic [CountW-1:0]  res_count_q;
  logic [SerialW-1:0] serial_q;

  logic               emit, emit_status;
  logic [WordW-1:0]   emit_word;
  logic [CountW-1:0]  emit_count;
  logic [SerialW-1:0] emit_serial;
  logic               full_pre, chk_ok, do_check;
  logic [WordW-1:0]   shifted, chk_word;
  logic [CountW-1:0]  bits_inc;
  logic [6:0]         sum7;

  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  // shift candidate and checksum word
  always_comb begin
    full_pre = (bits_q >= frame_bits_i);
    shifted  = {word_q[WordW-2:0], (q_item_i.kind == KIND_ONE)};
    bits_inc = bits_q + 1'b1;
    chk_word = full_pre ? word_q : shifted;
    sum7     = '0;
    // low 7 bits of bytes 0..6, byte 0 at the top of the word
    for (int k = 0; k < 7; k++) begin
      sum7 = sum7 + chk_word[WordW-8-8*k +: 7];
    end
    chk_ok = (sum7 == chk_word[6:0]);
  end

  // state update and result selection for a popped request
  always_comb begin
    word_d      = word_q;
    bits_d      = bits_q;
    decided_d   = decided_q;
    emit        = 1'b0;
    do_check    = 1'b0;
    emit_word   = word_q;
    emit_count  = bits_q;
    if (!decided_q) begin
      if (full_pre) begin
        emit     = 1'b1;
        do_check = 1'b1;
      end else if (q_item_i.kind == KIND_ZERO || q_item_i.kind == KIND_ONE) begin
        word_d     = shifted;
        bits_d     = bits_inc;
        emit_word  = shifted;
        emit_count = bits_inc;
        if (bits_inc >= frame_bits_i) begin
          emit     = 1'b1;
          do_check = 1'b1;
        end
      end else begin
        emit = 1'b1;
      end
    end
    decided_d = decided_q || emit;
    // end of capture without a decision is a failure
    if (q_item_i.eoc) begin
      if (!decided_d) begin
        emit = 1'b1;
      end
      word_d    = '0;
      bits_d    = '0;
      decided_d = 1'b0;
    end
    emit_status = !(do_check && chk_ok);
    emit_serial = emit_status ? '0 :
                  {chk_word[WordW-5 -: 2], 2'b00, chk_word[WordW-1 -: 4]};
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q    <= '0;
      bits_q    <= '0;
      decided_q <= 1'b0;
    end else if (q_pop_o) begin
      word_q    <= word_d;
      bits_q    <= bits_d;
      decided_q <= decided_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o && emit) begin
      status_q    <= emit_status;
      res_word_q  <= emit_word;
      res_count_q <= emit_count;
      serial_q    <= emit_serial;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_word_o   = res_word_q;
  assign out_count_o  = res_count_q;
  assign out_serial_o = serial_q;

`include "assert_macros.svh"
  `OWFD_ASSERT(a_ignore_decided, (q_pop_o && decided_q && !q_item_i.eoc) |-> !emit,
               "result after frame decision")
  `OWFD_ASSERT(a_eoc_clear, (q_pop_o && q_item_i.eoc) |=> (bits_q == '0 && !decided_q),
               "state not cleared at end of capture")

endmodule

// ===== tb/tb_top.sv =====
// testbench of the pulse-width weather frame decoder against the result stream
`timescale 1ns / 1ps

module tb_top;
  import owfd_pkg::*;

  // result fields of one decided frame
  typedef struct packed {
    logic        status;
    logic [63:0] data;
    logic [6:0]  count;
    logic [7:0]  serial;
  } frame_result_t;

  typedef struct packed {
    logic [15:0] hi;
    logic [15:0] lo;
  } pulse_pair_t;

  // clock, reset and block inputs, all known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = CFG_SHORT_TIME;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;

  ook_pwm_weather_frame_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // high_time [15:0], low_time [31:16]
    .s_axis_tlast  (s_axis_tlast),   // end_of_capture
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // frame_data [63:0], bit_count [70:64], serial_id [78:71]
    .m_axis_tuser  (m_axis_tuser)    // status
  );

  // predictor copy of the registers and the frame state
  logic [15:0] cfg_short = ShortReset;
  logic [15:0] cfg_long  = LongReset;
  logic [15:0] cfg_tol   = TolReset;
  logic [6:0]  cfg_bits  = BitsReset;
  logic [63:0] word_acc  = '0;
  logic [6:0]  taken     = '0;
  logic        frame_done = 1'b0;

  frame_result_t expected_frames[$];
  pulse_pair_t   capture_q[$];

  int error_count    = 0;
  int pairs_sent     = 0;
  int frames_checked = 0;
  int settings_used  = 1;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("timeout: run did not finish");
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= 100) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic near_time(logic [15:0] t, logic [15:0] nom);
    int d;
    d = (t > nom) ? int'(t) - int'(nom) : int'(nom) - int'(t);
    return d < int'(cfg_tol);
  endfunction

  // checksum over bytes 0..6 against byte 7, marks the frame decided
  function automatic frame_result_t frame_verdict();
    frame_result_t r;
    logic [7:0]    b0;
    int            sum;
    sum = 0;
    for (int k = 1; k < 8; k++) sum += int'(word_acc[8*k +: 8]);
    b0 = word_acc[63:56];
    frame_done = 1'b1;
    r.data  = word_acc;
    r.count = taken;
    if (sum[6:0] == word_acc[6:0]) begin
      r.status = 1'b0;
      r.serial = {b0[3:2], 2'b00, b0[7:4]};
    end else begin
      r.status = 1'b1;
      r.serial = '0;
    end
    return r;
  endfunction

  function automatic frame_result_t failed_result();
    frame_result_t r;
    frame_done = 1'b1;
    r.status = 1'b1;
    r.data   = word_acc;
    r.count  = taken;
    r.serial = '0;
    return r;
  endfunction

  // one accepted pulse pair: classify, shift, decide, clear on end of capture
  function automatic void predict_pair(logic [15:0] hi, logic [15:0] lo, logic eoc);
    frame_result_t r;
    logic          got;
    logic          hl, hs;
    int            gap;
    int            b;
    got = 1'b0;
    if (!frame_done) begin
      if (taken >= cfg_bits) begin
        r = frame_verdict();
        got = 1'b1;
      end else begin
        gap = int'(cfg_long) * 3;
        hl = near_time(hi, cfg_long);
        hs = near_time(hi, cfg_short);
        if (hl && near_time(lo, cfg_short)) b = 1;
        else if (hs && near_time(lo, cfg_long)) b = 0;
        else if (hs && int'(lo) > gap) b = 0;
        else if (hl && int'(lo) > gap) b = 1;
        else b = -1;
        if (b < 0) begin
          r = failed_result();
          got = 1'b1;
        end else begin
          word_acc = {word_acc[62:0], b[0]};
          taken = taken + 7'd1;
          if (taken >= cfg_bits) begin
            r = frame_verdict();
            got = 1'b1;
          end
        end
      end
    end
    if (eoc) begin
      if (!frame_done) begin
        r = failed_result();
        got = 1'b1;
      end
      word_acc = '0;
      taken = '0;
      frame_done = 1'b0;
    end
    if (got) expected_frames.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_results
    frame_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_frames.size() == 0) begin
        report_error($sformatf("unexpected result data=%h count=%0d status=%0b",
                               m_axis_tdata[63:0], m_axis_tdata[70:64], m_axis_tuser));
      end else begin
        exp_r = expected_frames.pop_front();
        frames_checked++;
        if (m_axis_tuser !== exp_r.status)
          report_error($sformatf("status got %0b exp %0b", m_axis_tuser, exp_r.status));
        if (m_axis_tdata[63:0] !== exp_r.data)
          report_error($sformatf("frame_data got %h exp %h", m_axis_tdata[63:0], exp_r.data));
        if (m_axis_tdata[70:64] !== exp_r.count)
          report_error($sformatf("bit_count got %0d exp %0d", m_axis_tdata[70:64],
                                 exp_r.count));
        if (m_axis_tdata[78:71] !== exp_r.serial)
          report_error($sformatf("serial_id got %h exp %h", m_axis_tdata[78:71],
                                 exp_r.serial));
      end
    end
  end

  // receiver stalls at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // mode 0: sender 24 / receiver 45, mode 1: swapped, mode 2: no idling
  task automatic set_idle_mode(int mode);
    case (mode)
      0: begin send_idle_pct = 24; recv_idle_pct = 45; end
      1: begin send_idle_pct = 45; recv_idle_pct = 24; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  // one request on the pair stream, entered and left at a falling edge
  task automatic send_pair(logic [15:0] hi, logic [15:0] lo, logic eoc);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {lo, hi};
    s_axis_tlast  <= eoc;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_pair(hi, lo, eoc);
    pairs_sent++;
    @(negedge clk_i);
  endtask

  // wait until every expected frame came out and the block has gone quiet
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CFG_SHORT_TIME: cfg_short = val;
      CFG_LONG_TIME:  cfg_long  = val;
      CFG_TOLERANCE:  cfg_tol   = val;
      CFG_FRAME_BITS: cfg_bits  = val[6:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [15:0] s, logic [15:0] l, logic [15:0] tol,
                               logic [6:0] nbits);
    write_reg(CFG_SHORT_TIME, s);
    write_reg(CFG_LONG_TIME, l);
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_FRAME_BITS, {9'd0, nbits});
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus shaping
  // ---------------------------------------------------------------------------

  // nominal time moved by less than the tolerance, clamped to the field
  function automatic logic [15:0] jitter_time(logic [15:0] nom);
    int span, t;
    if (cfg_tol <= 16'd1) return nom;
    span = int'(cfg_tol) - 1;
    t = int'(nom) + int'($urandom_range(2 * span, 0)) - span;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return t[15:0];
  endfunction

  function automatic pulse_pair_t bit_pair(logic b);
    pulse_pair_t p;
    int          gap;
    gap = int'(cfg_long) * 3;
    p.hi = jitter_time(b ? cfg_long : cfg_short);
    if (gap < 65535 && $urandom_range(99, 0) < 15)
      p.lo = 16'($urandom_range(65535, gap + 1));
    else
      p.lo = jitter_time(b ? cfg_short : cfg_long);
    return p;
  endfunction

  function automatic pulse_pair_t noise_pair();
    pulse_pair_t p;
    case ($urandom_range(3, 0))
      0: p = 32'($urandom);
      1: begin
        p.hi = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
        p.lo = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
      end
      2: begin
        p.hi = jitter_time(cfg_short);
        p.lo = jitter_time(cfg_short);
      end
      default: begin
        p.hi = jitter_time(cfg_long);
        p.lo = jitter_time(cfg_long);
      end
    endcase
    return p;
  endfunction

  // frame, with a valid checksum when it has at least 7 bits, optionally corrupted or cut short
  task automatic queue_frame(logic corrupt, logic truncate);
    logic [63:0] w;
    int          n, stop, sum, flip;
    n = int'(cfg_bits);
    w = {$urandom, $urandom};
    if (n < 64) w &= (64'd1 << n) - 64'd1;
    if (n >= 7) begin
      sum = 0;
      for (int k = 1; k < 8; k++) sum += int'(w[8*k +: 8]);
      w[6:0] = sum[6:0];
    end
    if (corrupt && n > 0) begin
      flip = $urandom_range(((n < 64) ? n : 64) - 1, 0);
      w[flip] = ~w[flip];
    end
    stop = (truncate && n > 0) ? int'($urandom_range(n - 1, 0)) : n;
    capture_q.delete();
    for (int i = n - 1; i >= n - stop; i--) begin
      if (i < 64) capture_q.push_back(bit_pair(w[i]));
      else capture_q.push_back(bit_pair(1'($urandom)));
    end
    if (truncate && $urandom_range(1, 0)) capture_q.push_back(noise_pair());
    repeat ($urandom_range(3, 0)) capture_q.push_back(noise_pair());
    if (capture_q.size() == 0) capture_q.push_back(noise_pair());
  endtask

  // send the queued capture, end of capture on its last pair
  task automatic play_capture();
    foreach (capture_q[i])
      send_pair(capture_q[i].hi, capture_q[i].lo, i == capture_q.size() - 1);
  endtask

  task automatic random_capture();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) begin
      queue_frame(1'b0, 1'b0);
    end else if (r < 70) begin
      queue_frame(1'b1, 1'b0);
    end else if (r < 85) begin
      queue_frame(1'b0, 1'b1);
    end else begin
      capture_q.delete();
      repeat ($urandom_range(4, 1)) capture_q.push_back(noise_pair());
    end
    play_capture();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // pair rules at the reset settings
  task automatic test_pair_rules();
    // zero times fail at once, the capture end after that adds nothing
    send_pair(16'd0, 16'd0, 1'b0);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
    // one, zero, zero on a gap, one on a gap, then an unmatched end pair
    send_pair(16'd400, 16'd200, 1'b0);
    send_pair(16'd200, 16'd400, 1'b0);
    send_pair(16'd200, 16'd1201, 1'b0);
    send_pair(16'd400, 16'hFFFF, 1'b0);
    send_pair(16'hFFFF, 16'd0, 1'b1);
    // capture ends before the frame is complete
    send_pair(16'd400, 16'd200, 1'b1);
    // tolerance edge: 90 off is no match, 89 off is
    send_pair(16'd489, 16'd111, 1'b0);
    send_pair(16'd110, 16'd490, 1'b1);
    drain_block();
  endtask

  // zero tolerance, zero frame bits, one frame bit
  task automatic test_corner_settings();
    write_reg(CFG_TOLERANCE, 16'd0);
    send_pair(16'd200, 16'd400, 1'b1);
    drain_block();
    write_reg(CFG_TOLERANCE, 16'd90);
    write_reg(CFG_FRAME_BITS, 16'd0);
    // decided on the current word without taking the pair
    send_pair(16'd12345, 16'd999, 1'b0);
    send_pair(16'd400, 16'd200, 1'b1);
    drain_block();
    write_reg(CFG_FRAME_BITS, 16'd1);
    send_pair(16'd200, 16'd400, 1'b0);
    send_pair(16'd400, 16'd200, 1'b1);
    send_pair(16'd400, 16'd200, 1'b1);
    drain_block();
    settings_used += 3;
  endtask

  // random captures under a sweep of register settings
  task automatic test_random_settings();
    int start;
    int budget;
    for (int s = 0; s < 9; s++) begin
      drain_block();
      set_idle_mode(s / 3);
      budget = 130;
      case (s)
        0: begin apply_setting(16'd200, 16'd400, 16'd90, 7'd64); budget = 150; end
        1: apply_setting(16'd1, 16'd3, 16'd1, 7'd8);
        2: apply_setting(16'd500, 16'd1500, 16'd300, 7'd40);
        3: apply_setting(16'd100, 16'd21845, 16'd50, 7'd16);
        4: begin apply_setting(16'd300, 16'd600, 16'd120, 7'd100); budget = 160; end
        5: apply_setting(16'd800, 16'd300, 16'd100, 7'd24);
        6: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd64);
        7: begin apply_setting(16'd150, 16'd450, 16'd60, 7'd127); budget = 220; end
        default: apply_setting(16'd1000, 16'd2000, 16'd400, 7'd1);
      endcase
      start = pairs_sent;
      while (pairs_sent - start < budget) random_capture();
    end
    drain_block();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    set_idle_mode(0);
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_pair_rules();
    test_corner_settings();
    test_random_settings();
    repeat (10) @(posedge clk_i);
    $display("summary: %0d pulse pairs sent under %0d register settings, %0d frames checked",
             pairs_sent, settings_used, frames_checked);
    $display("summary: %0d mismatches, %0d frames still expected", error_count,
             expected_frames.size());
    if (error_count == 0 && expected_frames.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
